// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/clcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_pkg
// Types, operation codes and saturating add for the CIGAR length summary.
// ----------------------------------------------------------------------------
package clcs_pkg;

  localparam int OP_W  = 4;
  localparam int LEN_W = 28;
  localparam int SUM_W = 31;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // CIGAR operation codes; codes above pad behave like none
  typedef enum logic [OP_W-1:0] {
    OP_NONE     = 4'd0,
    OP_MATCH    = 4'd1,
    OP_MISMATCH = 4'd2,
    OP_INSERT   = 4'd3,
    OP_DELETE   = 4'd4,
    OP_SKIP     = 4'd5,
    OP_SOFT     = 4'd6,
    OP_HARD     = 4'd7,
    OP_PAD      = 4'd8
  } op_code_t;

  typedef struct packed {
    logic [OP_W-1:0]  op_code;
    logic [LEN_W-1:0] run_length;
    logic             last_op;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0] query_length;
    logic [SUM_W-1:0] reference_span;
    logic [SUM_W-1:0] reference_span_with_soft;
    logic [SUM_W-1:0] leading_clips;
    logic [SUM_W-1:0] trailing_clips;
    logic             has_indel;
  } result_t;

  // Add a run length to a sum, clamping at the largest 31-bit value
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [LEN_W-1:0] len);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W-LEN_W+1){1'b0}}, len};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ===== hdl/clcs_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs channel interfaces
// Valid/ready channels for CIGAR operation words and summary words.
// ----------------------------------------------------------------------------
interface clcs_in_if;
  logic                              valid;
  logic                              ready;
  logic [clcs_pkg::OP_W-1:0]         op_code;
  logic [clcs_pkg::LEN_W-1:0]        run_length;
  logic                              last_op;

  modport source (output valid, output op_code, output run_length, output last_op,
                  input ready);
  modport sink   (input valid, input op_code, input run_length, input last_op,
                  output ready);
endinterface

interface clcs_out_if;
  logic                              valid;
  logic                              ready;
  logic [clcs_pkg::SUM_W-1:0]        query_length;
  logic [clcs_pkg::SUM_W-1:0]        reference_span;
  logic [clcs_pkg::SUM_W-1:0]        reference_span_with_soft;
  logic [clcs_pkg::SUM_W-1:0]        leading_clips;
  logic [clcs_pkg::SUM_W-1:0]        trailing_clips;
  logic                              has_indel;

  modport source (output valid, output query_length, output reference_span,
                  output reference_span_with_soft, output leading_clips,
                  output trailing_clips, output has_indel, input ready);
  modport sink   (input valid, input query_length, input reference_span,
                  input reference_span_with_soft, input leading_clips,
                  input trailing_clips, input has_indel, output ready);
endinterface

// ===== hdl/cigar_length_and_clip_summary.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_length_and_clip_summary
// Streams the CIGAR operations of reads and returns one length summary each.
//
// in_if  : one word per CIGAR operation (op_code, run_length, last_op).
// out_if : one summary word per read, sent after the word with last_op set:
//          query length, reference span, span with soft clips, leading and
//          trailing clip bases and an indel flag, each sum saturating at
//          2^31-1.
// Throughput: one operation word per cycle while no last word is held up;
// words of the next read may follow the last word of a read directly.
// Result path: the summary is folded in while the last word is in the input
// register and loads the result register when that word is consumed, which
// waits until the result register frees.
// Reset: synchronous, active low; both registers empty and all sums cleared.
// Stall: a held summary stays on out_if until taken; further non-last words
// keep flowing, and a last word waits in the input register until the
// result register frees, which then holds in_if.ready low.
// ----------------------------------------------------------------------------
module cigar_length_and_clip_summary (
  input  logic       clk,
  input  logic       rst_n,
  clcs_in_if.sink    in_if,
  clcs_out_if.source out_if
);
  import clcs_pkg::*;

  logic    stage_valid;
  item_t   stage_item;
  logic    slot_free;
  logic    adv;
  result_t result;

  // Consume the held word unless it ends a read and the result slot is busy
  assign adv = stage_valid && (!stage_item.last_op || slot_free);

  clcs_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .adv         (adv),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  clcs_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .item   (stage_item),
    .result (result)
  );

  clcs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && stage_item.last_op),
    .result    (result),
    .slot_free (slot_free),
    .out_if    (out_if)
  );

endmodule

// ===== hdl/clcs_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_in_stage
// Input register: captures one operation word and holds it until consumed.
// ----------------------------------------------------------------------------
module clcs_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  clcs_in_if.sink         in_if,
  input  logic            adv,
  output logic            stage_valid,
  output clcs_pkg::item_t stage_item
);
  import clcs_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Take a new word whenever the register is empty or draining this cycle
  assign in_if.ready = !valid_r || adv;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload; no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op_code    <= in_if.op_code;
      item_r.run_length <= in_if.run_length;
      item_r.last_op    <= in_if.last_op;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

// ===== hdl/clcs_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_accum
// Running sums for one read; builds the summary on the last operation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clcs_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  clcs_pkg::item_t   item,
  output clcs_pkg::result_t result
);
  import clcs_pkg::*;

  logic [SUM_W-1:0] query_sum_r, query_sum_nxt;
  logic [SUM_W-1:0] ref_sum_r, ref_sum_nxt;
  logic [SUM_W-1:0] ref_soft_sum_r, ref_soft_sum_nxt;
  logic [SUM_W-1:0] lead_clip_sum_r, lead_clip_sum_nxt;
  logic             lead_closed_r, lead_closed_nxt;
  logic [SUM_W-1:0] trail_clip_sum_r, trail_clip_sum_nxt;
  logic             indel_seen_r, indel_seen_nxt;

  logic             in_query, in_ref, is_soft, is_clip, is_indel;
  logic [SUM_W-1:0] query_upd, ref_upd, ref_soft_upd, lead_upd, trail_upd;
  logic             closed_upd, indel_upd;

  // Decode the operation class
  always_comb begin
    in_query = 1'b0;
    in_ref   = 1'b0;
    is_soft  = 1'b0;
    is_clip  = 1'b0;
    is_indel = 1'b0;
    case (item.op_code)
      OP_MATCH, OP_MISMATCH: begin
        in_query = 1'b1;
        in_ref   = 1'b1;
      end
      OP_INSERT: begin
        in_query = 1'b1;
        is_indel = 1'b1;
      end
      OP_DELETE: begin
        in_ref   = 1'b1;
        is_indel = 1'b1;
      end
      OP_SKIP: begin
        in_ref = 1'b1;
      end
      OP_SOFT: begin
        in_query = 1'b1;
        is_soft  = 1'b1;
        is_clip  = 1'b1;
      end
      OP_HARD: begin
        is_clip = 1'b1;
      end
      default: begin
        // none, pad and unused codes add nothing but close the clip runs
      end
    endcase
  end

  // Sums after this operation is folded in
  always_comb begin
    query_upd    = in_query ? sat_add(query_sum_r, item.run_length) : query_sum_r;
    ref_upd      = in_ref ? sat_add(ref_sum_r, item.run_length) : ref_sum_r;
    ref_soft_upd = (in_ref || is_soft) ? sat_add(ref_soft_sum_r, item.run_length)
                                       : ref_soft_sum_r;
    indel_upd    = indel_seen_r || is_indel;
    lead_upd     = (is_clip && !lead_closed_r) ? sat_add(lead_clip_sum_r, item.run_length)
                                               : lead_clip_sum_r;
    closed_upd   = lead_closed_r || !is_clip;
    trail_upd    = is_clip ? sat_add(trail_clip_sum_r, item.run_length) : '0;
  end

  // Advance on each consumed word; clear after the last one of a read
  always_comb begin
    query_sum_nxt      = query_sum_r;
    ref_sum_nxt        = ref_sum_r;
    ref_soft_sum_nxt   = ref_soft_sum_r;
    lead_clip_sum_nxt  = lead_clip_sum_r;
    lead_closed_nxt    = lead_closed_r;
    trail_clip_sum_nxt = trail_clip_sum_r;
    indel_seen_nxt     = indel_seen_r;
    if (fire) begin
      if (item.last_op) begin
        query_sum_nxt      = '0;
        ref_sum_nxt        = '0;
        ref_soft_sum_nxt   = '0;
        lead_clip_sum_nxt  = '0;
        lead_closed_nxt    = 1'b0;
        trail_clip_sum_nxt = '0;
        indel_seen_nxt     = 1'b0;
      end else begin
        query_sum_nxt      = query_upd;
        ref_sum_nxt        = ref_upd;
        ref_soft_sum_nxt   = ref_soft_upd;
        lead_clip_sum_nxt  = lead_upd;
        lead_closed_nxt    = closed_upd;
        trail_clip_sum_nxt = trail_upd;
        indel_seen_nxt     = indel_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_sum_r      <= '0;
      ref_sum_r        <= '0;
      ref_soft_sum_r   <= '0;
      lead_clip_sum_r  <= '0;
      lead_closed_r    <= 1'b0;
      trail_clip_sum_r <= '0;
      indel_seen_r     <= 1'b0;
    end else begin
      query_sum_r      <= query_sum_nxt;
      ref_sum_r        <= ref_sum_nxt;
      ref_soft_sum_r   <= ref_soft_sum_nxt;
      lead_clip_sum_r  <= lead_clip_sum_nxt;
      lead_closed_r    <= lead_closed_nxt;
      trail_clip_sum_r <= trail_clip_sum_nxt;
      indel_seen_r     <= indel_seen_nxt;
    end
  end

  // Summary including the current word
  assign result.query_length             = query_upd;
  assign result.reference_span           = ref_upd;
  assign result.reference_span_with_soft = ref_soft_upd;
  assign result.leading_clips            = lead_upd;
  assign result.trailing_clips           = trail_upd;
  assign result.has_indel                = indel_upd;

  // While no non-clip op has been seen, both clip runs count the same bases
  `ASSERT_IMPLIES(a_clip_runs_match, clk, rst_n, !lead_closed_r, lead_clip_sum_r == trail_clip_sum_r, "leading and trailing clip sums differ before first non-clip op")
  // A consumed non-clip op empties the trailing clip run
  `ASSERT_NEXT(a_trail_cleared, clk, rst_n, fire && !is_clip, trail_clip_sum_r == '0, "trailing clip sum not cleared by non-clip op")
  // The last op of a read leaves the query and reference sums and both flags cleared
  `ASSERT_NEXT(a_read_cleared, clk, rst_n, fire && item.last_op, (query_sum_r == '0) && (ref_sum_r == '0) && (ref_soft_sum_r == '0) && !lead_closed_r && !indel_seen_r, "state not cleared after last op")

endmodule

// ===== hdl/clcs_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_out_stage
// Result register: holds one summary word until the receiver takes it.
// ----------------------------------------------------------------------------
module clcs_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  clcs_pkg::result_t result,
  output logic              slot_free,
  clcs_out_if.source        out_if
);
  import clcs_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Free when empty or when the held word leaves this cycle
  assign slot_free = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_if.valid                    = valid_r;
  assign out_if.query_length             = res_r.query_length;
  assign out_if.reference_span           = res_r.reference_span;
  assign out_if.reference_span_with_soft = res_r.reference_span_with_soft;
  assign out_if.leading_clips            = res_r.leading_clips;
  assign out_if.trailing_clips           = res_r.trailing_clips;
  assign out_if.has_indel                = res_r.has_indel;

endmodule
